// ----- hdl/frma_pkg.sv -----
// ----------------------------------------------------------------------------
// Frame rate meter package
// Shared widths, constants and the sequencer state type of the moving-average
// frame rate meter.
// ----------------------------------------------------------------------------
package frma_pkg;

    // Field widths of the input and result streams.
    localparam int TIME_W      = 32;
    localparam int FPS_W       = 23;
    localparam int TDATA_OUT_W = 24;

    // Default averaging window, in frames.
    localparam int WINDOW_DEFAULT = 30;

    // 1000 ms per second scaled by 256 for eight fraction bits.
    localparam int          SCALE_W  = 18;
    localparam logic [17:0] SCALE_Q8 = 18'd256000;

    // Largest reportable rate.
    localparam logic [FPS_W-1:0] FPS_MAX = {FPS_W{1'b1}};

    // Request kinds carried on the input tuser.
    localparam logic KIND_RESTART = 1'b0;
    localparam logic KIND_FRAME   = 1'b1;

    // Sequencer states, one-hot.
    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_SUB  = 6'b000010,
        ST_ADD  = 6'b000100,
        ST_MUL  = 6'b001000,
        ST_DIV  = 6'b010000,
        ST_DONE = 6'b100000
    } state_t;

endpackage

// ----- hdl/frame_rate_moving_average_core.sv -----
// ----------------------------------------------------------------------------
// Moving-average frame rate meter
// Keeps the last WINDOW frame intervals in a small ring memory and reports
// frames per second as floor(256000 * count / sum) in unsigned Q15.8.
// ----------------------------------------------------------------------------
// Each request carries a millisecond timestamp on s_tdata and a kind on
// s_tuser (0 restarts the measurement, 1 marks a shown frame). Every request
// produces exactly one result. The block works on one request at a time and
// holds s_tready low while it does. A restart goes straight from acceptance
// to ST_DONE, which loads the output register. A frame request steps through
// dropping the oldest interval, adding the new interval and forming the
// numerator, then a restoring divider that produces one quotient bit per
// cycle, and last the load of the output register; a zero interval sum skips
// the divider and reports the largest rate with m_tuser set. s_tready returns
// in the cycle after the result is loaded, so no new request is taken before
// the last one is through. A result that still waits on m_tready holds the
// next request in its final cycle. The next request is taken as soon as the
// block is idle, even while an earlier result still waits on m_tready. No
// clearing pass is needed after reset; the ring is read only at entries
// written since the last reset or restart.
module frame_rate_moving_average_core #(
    parameter int WINDOW = frma_pkg::WINDOW_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Input stream.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [frma_pkg::TIME_W-1:0]         s_tdata,   // [31:0] time_ms
    input  logic [0:0]                          s_tuser,   // [0] kind
    // Result stream.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [frma_pkg::TDATA_OUT_W-1:0]    m_tdata,   // [22:0] fps_q8, [23] zero fill
    output logic [0:0]                          m_tuser    // [0] zero_interval
);
    import frma_pkg::*;

    // Derived widths.
    localparam int POS_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int SUM_W  = TIME_W + $clog2(WINDOW);
    localparam int NUM_W  = SCALE_W + CNT_W;
    localparam int DIV_W  = (NUM_W > FPS_W + 1) ? NUM_W : FPS_W + 1;
    localparam int STEP_W = $clog2(DIV_W);

    // Ring of intervals.
    logic [TIME_W-1:0] ring_mem [WINDOW];
    logic [TIME_W-1:0] rd_data_reg;

    state_t             state_reg, state_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [TIME_W-1:0]  prev_reg, prev_next;
    logic [TIME_W-1:0]  delta_reg, delta_next;
    logic [DIV_W-1:0]   quot_reg, quot_next;
    logic [SUM_W-1:0]   rem_reg, rem_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic               zero_reg, zero_next;
    logic               out_valid_reg, out_valid_next;
    logic [FPS_W-1:0]   out_fps_reg, out_fps_next;
    logic               out_zero_reg, out_zero_next;

    logic               s_accept;
    logic               window_full;
    logic               ring_write;
    logic [SUM_W:0]     trial;
    logic               trial_ge;

    assign s_accept    = s_tvalid && s_tready;
    assign s_tready    = (state_reg == ST_IDLE);
    assign window_full = (count_reg == CNT_W'(WINDOW));
    assign ring_write  = (state_reg == ST_ADD);

    // Divider step: bring down the next numerator bit and try a subtract.
    assign trial    = {rem_reg, quot_reg[DIV_W-1]};
    assign trial_ge = (trial >= {1'b0, sum_reg});

    // Ring memory with a registered read at the current position.
    always_ff @(posedge aclk) begin
        if (ring_write) begin
            ring_mem[pos_reg] <= delta_reg;
        end
        rd_data_reg <= ring_mem[pos_reg];
    end

    // Sequencer and datapath next-state logic.
    always_comb begin
        state_next     = state_reg;
        sum_next       = sum_reg;
        pos_next       = pos_reg;
        count_next     = count_reg;
        prev_next      = prev_reg;
        delta_next     = delta_reg;
        quot_next      = quot_reg;
        rem_next       = rem_reg;
        step_next      = step_reg;
        zero_next      = zero_reg;
        out_valid_next = out_valid_reg;
        out_fps_next   = out_fps_reg;
        out_zero_next  = out_zero_reg;

        // The consumer takes the waiting result.
        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    prev_next = s_tdata;
                    if (s_tuser[0] == KIND_RESTART) begin
                        sum_next   = '0;
                        pos_next   = '0;
                        count_next = '0;
                        quot_next  = '0;
                        zero_next  = 1'b0;
                        state_next = ST_DONE;
                    end else begin
                        delta_next = s_tdata - prev_reg;
                        state_next = ST_SUB;
                    end
                end
            end
            ST_SUB: begin
                // Drop the oldest interval once the window is full.
                if (window_full) begin
                    sum_next = sum_reg - SUM_W'(rd_data_reg);
                end else begin
                    count_next = count_reg + CNT_W'(1);
                end
                state_next = ST_ADD;
            end
            ST_ADD: begin
                // The new interval goes into the ring at this position.
                sum_next   = sum_reg + SUM_W'(delta_reg);
                pos_next   = (pos_reg == POS_W'(WINDOW - 1)) ? '0 : pos_reg + POS_W'(1);
                state_next = ST_MUL;
            end
            ST_MUL: begin
                if (sum_reg == '0) begin
                    quot_next  = DIV_W'(FPS_MAX);
                    zero_next  = 1'b1;
                    state_next = ST_DONE;
                end else begin
                    quot_next  = DIV_W'(SCALE_Q8) * DIV_W'(count_reg);
                    rem_next   = '0;
                    step_next  = STEP_W'(DIV_W - 1);
                    zero_next  = 1'b0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                // One quotient bit per cycle, shifted in behind the numerator.
                if (trial_ge) begin
                    rem_next = SUM_W'(trial - {1'b0, sum_reg});
                end else begin
                    rem_next = trial[SUM_W-1:0];
                end
                quot_next = {quot_reg[DIV_W-2:0], trial_ge};
                step_next = step_reg - STEP_W'(1);
                if (step_reg == '0) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                // Load the output register once it is free.
                if (!out_valid_reg || m_tready) begin
                    out_valid_next = 1'b1;
                    out_zero_next  = zero_reg;
                    if (quot_reg > DIV_W'(FPS_MAX)) begin
                        out_fps_next = FPS_MAX;
                    end else begin
                        out_fps_next = quot_reg[FPS_W-1:0];
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            sum_reg       <= '0;
            pos_reg       <= '0;
            count_reg     <= '0;
            prev_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            sum_reg       <= sum_next;
            pos_reg       <= pos_next;
            count_reg     <= count_next;
            prev_reg      <= prev_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        delta_reg    <= delta_next;
        quot_reg     <= quot_next;
        rem_reg      <= rem_next;
        step_reg     <= step_next;
        zero_reg     <= zero_next;
        out_fps_reg  <= out_fps_next;
        out_zero_reg <= out_zero_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = TDATA_OUT_W'(out_fps_reg);
    assign m_tuser  = out_zero_reg;

endmodule
